// ===== rtl/tracked_position_hysteresis_speed_assert.svh =====
// Assertion macros shared by the tracked position block.
// Depends on nothing; included by tphs_dp, the only RTL file that carries assertions.
`ifndef TRACKED_POSITION_HYSTERESIS_SPEED_ASSERT_SVH
`define TRACKED_POSITION_HYSTERESIS_SPEED_ASSERT_SVH

// Checked at every clock edge outside reset.
`define TPHS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define TPHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/tphs_pkg.sv =====
// Shared types and constants of the tracked position block.
// Depends on nothing; used by every RTL module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tphs_pkg;

    // Fixed field widths
    localparam int Q16_W     = 16;
    localparam int SPEED_W   = 24;
    localparam int SQ_W      = 33;   // dx^2 + dy^2
    localparam int ROOT_W    = 17;
    localparam int SCALE_W   = 20;
    localparam int PROD_W    = ROOT_W + SCALE_W;
    localparam int LO_W      = SPEED_W;  // dividend bits shifted in by the divider
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 8;
    localparam int OUT_W     = 1 + 2 * Q16_W + SPEED_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_W;
    localparam int OUT_TUSER_W = 2;

    localparam logic [Q16_W-1:0]   Q16_MAX     = 16'hFFFF;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 24'hFFFFFF;
    localparam logic [SCALE_W-1:0] SPEED_SCALE = 20'd1000000;

    localparam logic [STEP_W-1:0] DIV_STEPS_NORM  = 5'd16;
    localparam logic [STEP_W-1:0] DIV_STEPS_SPEED = 5'd24;

    // Register reset values
    localparam int unsigned FRAME_WIDTH_RST  = 640;
    localparam int unsigned FRAME_HEIGHT_RST = 480;
    localparam int unsigned STAB_THR_RST     = 655;
    localparam int unsigned INTERVAL_RST     = 100000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STAB_THR     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL     = 8'd3;

    // Datapath commands
    typedef logic [3:0] tphs_cmd_t;
    localparam tphs_cmd_t CMD_NONE   = 4'd0;
    localparam tphs_cmd_t CMD_LOAD   = 4'd1;
    localparam tphs_cmd_t CMD_LOST   = 4'd2;
    localparam tphs_cmd_t CMD_DIVX   = 4'd3;
    localparam tphs_cmd_t CMD_STX    = 4'd4;
    localparam tphs_cmd_t CMD_DIVY   = 4'd5;
    localparam tphs_cmd_t CMD_STY    = 4'd6;
    localparam tphs_cmd_t CMD_UPD    = 4'd7;
    localparam tphs_cmd_t CMD_SQ1    = 4'd8;
    localparam tphs_cmd_t CMD_SQ2    = 4'd9;
    localparam tphs_cmd_t CMD_ROOT   = 4'd10;
    localparam tphs_cmd_t CMD_MUL    = 4'd11;
    localparam tphs_cmd_t CMD_SPD    = 4'd12;
    localparam tphs_cmd_t CMD_STSPD  = 4'd13;
    localparam tphs_cmd_t CMD_REF    = 4'd14;
    localparam tphs_cmd_t CMD_EMIT   = 4'd15;

    // Datapath status back to the controller
    typedef struct packed {
        logic seen;       // both pixel coordinates nonzero
        logic trig;       // reference interval elapsed or no reference time
        logic have_ref;
        logic div_done;
        logic root_done;
        logic out_free;   // output register can take a result
    } tphs_status_t;

endpackage

`default_nettype wire

// ===== rtl/tphs_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tphs_pkg for the step and quotient widths.
`timescale 1ns / 1ps
`default_nettype none

module tphs_div #(
    parameter int DW = 32
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             start,
    input  wire [DW-1:0]                    rem_init,   // high part, below divisor
    input  wire [tphs_pkg::LO_W-1:0]        lo_init,    // low bits, shifted in msb first
    input  wire [DW-1:0]                    divisor,
    input  wire [tphs_pkg::STEP_W-1:0]      steps,
    output logic                            done,
    output logic [tphs_pkg::LO_W-1:0]       quot
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [tphs_pkg::STEP_W-1:0]    cnt_reg;
    logic [DW-1:0]                  rem_reg;
    logic [DW-1:0]                  div_reg;
    logic [tphs_pkg::LO_W-1:0]      lo_reg;
    logic [tphs_pkg::LO_W-1:0]      quot_reg;

    logic [DW:0] trial;
    logic        fits;
    logic [DW:0] diff;

    // One restoring step
    always_comb begin
        trial = {rem_reg, lo_reg[tphs_pkg::LO_W-1]};
        fits  = trial >= {1'b0, div_reg};
        diff  = trial - {1'b0, div_reg};
    end

    // Sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - tphs_pkg::STEP_W'(1);
                if (cnt_reg == tphs_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= rem_init;
            lo_reg   <= lo_init;
            div_reg  <= divisor;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? diff[DW-1:0] : trial[DW-1:0];
            lo_reg   <= {lo_reg[tphs_pkg::LO_W-2:0], 1'b0};
            quot_reg <= {quot_reg[tphs_pkg::LO_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ===== rtl/tphs_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on tphs_pkg for the radicand and root widths.
`timescale 1ns / 1ps
`default_nettype none

module tphs_isqrt (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire [tphs_pkg::SQ_W-1:0]     radicand,
    output logic                         done,
    output logic [tphs_pkg::ROOT_W-1:0]  root
);

    localparam int RES_W   = tphs_pkg::SQ_W + 1;
    localparam int TOP_BIT = ((tphs_pkg::SQ_W - 1) / 2) * 2;

    logic                       busy_reg;
    logic                       done_reg;
    logic [tphs_pkg::SQ_W-1:0]  v_reg;
    logic [tphs_pkg::SQ_W-1:0]  bit_reg;
    logic [RES_W-1:0]           res_reg;

    logic [RES_W-1:0] sum;
    logic             take;

    always_comb begin
        sum  = res_reg + RES_W'(bit_reg);
        take = {1'b0, v_reg} >= sum;
    end

    // Sequencing: finish after the step on the lowest bit pair
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Digit-by-digit root
    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= tphs_pkg::SQ_W'(1) << TOP_BIT;
        end else if (busy_reg) begin
            if (take) begin
                v_reg   <= v_reg - sum[tphs_pkg::SQ_W-1:0];
                res_reg <= (res_reg >> 1) + RES_W'(bit_reg);
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[tphs_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/tphs_ctrl.sv =====
// Controller state machine: sequences the datapath for each request.
// Depends on tphs_pkg for commands and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module tphs_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  tphs_pkg::tphs_status_t  status,
    output tphs_pkg::tphs_cmd_t     cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CHECK     = 4'd1;
    localparam logic [3:0] S_X_WAIT    = 4'd2;
    localparam logic [3:0] S_Y_GO      = 4'd3;
    localparam logic [3:0] S_Y_WAIT    = 4'd4;
    localparam logic [3:0] S_UPD       = 4'd5;
    localparam logic [3:0] S_BRANCH    = 4'd6;
    localparam logic [3:0] S_SQ1       = 4'd7;
    localparam logic [3:0] S_SQ2       = 4'd8;
    localparam logic [3:0] S_ROOT_GO   = 4'd9;
    localparam logic [3:0] S_ROOT_WAIT = 4'd10;
    localparam logic [3:0] S_MUL       = 4'd11;
    localparam logic [3:0] S_SPD_GO    = 4'd12;
    localparam logic [3:0] S_SPD_WAIT  = 4'd13;
    localparam logic [3:0] S_REF       = 4'd14;
    localparam logic [3:0] S_OUT       = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Next state and command
    always_comb begin
        state_next = state_reg;
        cmd        = tphs_pkg::CMD_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd        = tphs_pkg::CMD_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (status.seen) begin
                    cmd        = tphs_pkg::CMD_DIVX;
                    state_next = S_X_WAIT;
                end else begin
                    cmd        = tphs_pkg::CMD_LOST;
                    state_next = S_OUT;
                end
            end
            S_X_WAIT: begin
                if (status.div_done) begin
                    cmd        = tphs_pkg::CMD_STX;
                    state_next = S_Y_GO;
                end
            end
            S_Y_GO: begin
                cmd        = tphs_pkg::CMD_DIVY;
                state_next = S_Y_WAIT;
            end
            S_Y_WAIT: begin
                if (status.div_done) begin
                    cmd        = tphs_pkg::CMD_STY;
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                cmd        = tphs_pkg::CMD_UPD;
                state_next = S_BRANCH;
            end
            S_BRANCH: begin
                if (!status.trig) begin
                    state_next = S_OUT;
                end else if (status.have_ref) begin
                    state_next = S_SQ1;
                end else begin
                    state_next = S_REF;
                end
            end
            S_SQ1: begin
                cmd        = tphs_pkg::CMD_SQ1;
                state_next = S_SQ2;
            end
            S_SQ2: begin
                cmd        = tphs_pkg::CMD_SQ2;
                state_next = S_ROOT_GO;
            end
            S_ROOT_GO: begin
                cmd        = tphs_pkg::CMD_ROOT;
                state_next = S_ROOT_WAIT;
            end
            S_ROOT_WAIT: begin
                if (status.root_done) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd        = tphs_pkg::CMD_MUL;
                state_next = S_SPD_GO;
            end
            S_SPD_GO: begin
                cmd        = tphs_pkg::CMD_SPD;
                state_next = S_SPD_WAIT;
            end
            S_SPD_WAIT: begin
                if (status.div_done) begin
                    cmd        = tphs_pkg::CMD_STSPD;
                    state_next = S_REF;
                end
            end
            S_REF: begin
                cmd        = tphs_pkg::CMD_REF;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd        = tphs_pkg::CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/tphs_dp.sv =====
// Datapath: registers, tracking state, arithmetic units and output register.
// Depends on tphs_pkg, tphs_div, tphs_isqrt and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "tracked_position_hysteresis_speed_assert.svh"

module tphs_dp #(
    parameter int PIXEL_BITS = 12,
    parameter int TIME_BITS  = 32
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  tphs_pkg::tphs_cmd_t                 cmd,
    output tphs_pkg::tphs_status_t              status,
    input  wire [PIXEL_BITS-1:0]                pixel_x,
    input  wire [PIXEL_BITS-1:0]                pixel_y,
    input  wire [TIME_BITS-1:0]                 time_us,
    input  wire                                 cfg_valid,
    input  wire [tphs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [TIME_BITS-1:0]                 cfg_data,
    input  wire                                 m_tready,
    output logic                                m_tvalid,
    output logic                                changed,
    output logic                                detected,
    output logic [tphs_pkg::Q16_W-1:0]          pos_x,
    output logic [tphs_pkg::Q16_W-1:0]          pos_y,
    output logic                                speed_valid,
    output logic [tphs_pkg::SPEED_W-1:0]        speed
);

    localparam int DW = (PIXEL_BITS > TIME_BITS) ? PIXEL_BITS : TIME_BITS;
    localparam int QW = tphs_pkg::Q16_W;

    function automatic logic [QW-1:0] absdiff(input logic [QW-1:0] a, input logic [QW-1:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

    // Configuration
    logic [PIXEL_BITS-1:0] fw_reg;
    logic [PIXEL_BITS-1:0] fh_reg;
    logic [QW-1:0]         thr_reg;
    logic [TIME_BITS-1:0]  iv_reg;

    // Tracking flags
    logic have_pos_reg;
    logic have_ref_reg;
    logic have_since_reg;
    logic have_speed_reg;
    logic change_reg;
    logic trig_reg;
    logic m_tvalid_reg;

    // Payload
    logic [PIXEL_BITS-1:0]          px_reg;
    logic [PIXEL_BITS-1:0]          py_reg;
    logic [TIME_BITS-1:0]           t_reg;
    logic [QW-1:0]                  nx_reg;
    logic [QW-1:0]                  ny_reg;
    logic [QW-1:0]                  cur_x_reg;
    logic [QW-1:0]                  cur_y_reg;
    logic [QW-1:0]                  ref_x_reg;
    logic [QW-1:0]                  ref_y_reg;
    logic [TIME_BITS-1:0]           since_reg;
    logic [TIME_BITS-1:0]           elapsed_reg;
    logic [tphs_pkg::SPEED_W-1:0]   cur_speed_reg;
    logic [tphs_pkg::SQ_W-1:0]      sq_reg;
    logic [tphs_pkg::PROD_W-1:0]    prod_reg;

    logic                           out_changed_reg;
    logic                           out_detected_reg;
    logic [QW-1:0]                  out_x_reg;
    logic [QW-1:0]                  out_y_reg;
    logic                           out_spd_valid_reg;
    logic [tphs_pkg::SPEED_W-1:0]   out_speed_reg;

    // Arithmetic units
    logic                           div_start;
    logic [DW-1:0]                  div_rem;
    logic [tphs_pkg::LO_W-1:0]      div_lo;
    logic [DW-1:0]                  div_divisor;
    logic [tphs_pkg::STEP_W-1:0]    div_steps;
    logic                           div_done;
    logic [tphs_pkg::LO_W-1:0]      div_quot;
    logic                           root_done;
    logic [tphs_pkg::ROOT_W-1:0]    root;

    logic [TIME_BITS-1:0]           elapsed;
    logic [QW-1:0]                  dx;
    logic [QW-1:0]                  dy;
    logic [2*QW-1:0]                dx_sq;
    logic [2*QW-1:0]                dy_sq;
    logic                           norm_sat_x;
    logic                           norm_sat_y;
    logic                           speed_sat;
    logic                           out_free;

    always_comb begin
        elapsed    = t_reg - since_reg;
        dx         = absdiff(ref_x_reg, cur_x_reg);
        dy         = absdiff(ref_y_reg, cur_y_reg);
        dx_sq      = (2*QW)'(dx) * (2*QW)'(dx);
        dy_sq      = (2*QW)'(dy) * (2*QW)'(dy);
        // pixel at or beyond the frame size (or a zero size) saturates
        norm_sat_x = px_reg >= fw_reg;
        norm_sat_y = py_reg >= fh_reg;
        // quotient overflows 24 bits when the high part reaches the divisor
        speed_sat  = DW'(prod_reg[tphs_pkg::PROD_W-1:tphs_pkg::LO_W]) >= DW'(elapsed_reg);
        out_free   = !m_tvalid_reg || m_tready;
    end

    // Divider operand select
    always_comb begin
        div_start   = 1'b0;
        div_rem     = DW'(px_reg);
        div_lo      = '0;
        div_divisor = DW'(fw_reg);
        div_steps   = tphs_pkg::DIV_STEPS_NORM;
        case (cmd)
            tphs_pkg::CMD_DIVX: begin
                div_start = 1'b1;
            end
            tphs_pkg::CMD_DIVY: begin
                div_start   = 1'b1;
                div_rem     = DW'(py_reg);
                div_divisor = DW'(fh_reg);
            end
            tphs_pkg::CMD_SPD: begin
                div_start   = 1'b1;
                div_rem     = DW'(prod_reg[tphs_pkg::PROD_W-1:tphs_pkg::LO_W]);
                div_lo      = prod_reg[tphs_pkg::LO_W-1:0];
                div_divisor = DW'(elapsed_reg);
                div_steps   = tphs_pkg::DIV_STEPS_SPEED;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    tphs_div #(
        .DW(DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem),
        .lo_init  (div_lo),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quot     (div_quot)
    );

    tphs_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd == tphs_pkg::CMD_ROOT),
        .radicand (sq_reg),
        .done     (root_done),
        .root     (root)
    );

    // Configuration and control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg         <= PIXEL_BITS'(tphs_pkg::FRAME_WIDTH_RST);
            fh_reg         <= PIXEL_BITS'(tphs_pkg::FRAME_HEIGHT_RST);
            thr_reg        <= QW'(tphs_pkg::STAB_THR_RST);
            iv_reg         <= TIME_BITS'(tphs_pkg::INTERVAL_RST);
            have_pos_reg   <= 1'b0;
            have_ref_reg   <= 1'b0;
            have_since_reg <= 1'b0;
            have_speed_reg <= 1'b0;
            change_reg     <= 1'b0;
            trig_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    tphs_pkg::REG_FRAME_WIDTH:  fw_reg  <= cfg_data[PIXEL_BITS-1:0];
                    tphs_pkg::REG_FRAME_HEIGHT: fh_reg  <= cfg_data[PIXEL_BITS-1:0];
                    tphs_pkg::REG_STAB_THR:     thr_reg <= cfg_data[QW-1:0];
                    tphs_pkg::REG_INTERVAL:     iv_reg  <= cfg_data;
                    default: ;
                endcase
            end

            case (cmd)
                tphs_pkg::CMD_LOAD: begin
                    change_reg <= 1'b0;
                end
                tphs_pkg::CMD_LOST: begin
                    change_reg     <= have_pos_reg;
                    have_pos_reg   <= 1'b0;
                    have_ref_reg   <= 1'b0;
                    have_since_reg <= 1'b0;
                    have_speed_reg <= 1'b0;
                end
                tphs_pkg::CMD_UPD: begin
                    trig_reg <= !have_since_reg || (elapsed > iv_reg);
                    if (!have_pos_reg) begin
                        have_pos_reg <= 1'b1;
                        change_reg   <= 1'b1;
                    end else if ((absdiff(cur_x_reg, nx_reg) > thr_reg)
                                 || (absdiff(cur_y_reg, ny_reg) > thr_reg)) begin
                        change_reg <= 1'b1;
                    end
                end
                tphs_pkg::CMD_STSPD: begin
                    have_speed_reg <= 1'b1;
                    change_reg     <= 1'b1;
                end
                tphs_pkg::CMD_REF: begin
                    have_ref_reg   <= 1'b1;
                    have_since_reg <= 1'b1;
                end
                default: ;
            endcase

            // Output register handshake
            if (cmd == tphs_pkg::CMD_EMIT) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        case (cmd)
            tphs_pkg::CMD_LOAD: begin
                px_reg <= pixel_x;
                py_reg <= pixel_y;
                t_reg  <= time_us;
            end
            tphs_pkg::CMD_STX: begin
                nx_reg <= norm_sat_x ? tphs_pkg::Q16_MAX : div_quot[QW-1:0];
            end
            tphs_pkg::CMD_STY: begin
                ny_reg <= norm_sat_y ? tphs_pkg::Q16_MAX : div_quot[QW-1:0];
            end
            tphs_pkg::CMD_UPD: begin
                elapsed_reg <= elapsed;
                // hysteresis: move a coordinate only past the band
                if (!have_pos_reg || (absdiff(cur_x_reg, nx_reg) > thr_reg)) begin
                    cur_x_reg <= nx_reg;
                end
                if (!have_pos_reg || (absdiff(cur_y_reg, ny_reg) > thr_reg)) begin
                    cur_y_reg <= ny_reg;
                end
            end
            tphs_pkg::CMD_SQ1: begin
                sq_reg <= {1'b0, dx_sq};
            end
            tphs_pkg::CMD_SQ2: begin
                sq_reg <= sq_reg + {1'b0, dy_sq};
            end
            tphs_pkg::CMD_MUL: begin
                prod_reg <= tphs_pkg::PROD_W'(root) * tphs_pkg::PROD_W'(tphs_pkg::SPEED_SCALE);
            end
            tphs_pkg::CMD_STSPD: begin
                cur_speed_reg <= speed_sat ? tphs_pkg::SPEED_MAX : div_quot;
            end
            tphs_pkg::CMD_REF: begin
                ref_x_reg <= cur_x_reg;
                ref_y_reg <= cur_y_reg;
                since_reg <= t_reg;
            end
            tphs_pkg::CMD_EMIT: begin
                out_changed_reg   <= change_reg;
                out_detected_reg  <= have_pos_reg;
                out_x_reg         <= have_pos_reg ? cur_x_reg : '0;
                out_y_reg         <= have_pos_reg ? cur_y_reg : '0;
                out_spd_valid_reg <= have_speed_reg;
                out_speed_reg     <= have_speed_reg ? cur_speed_reg : '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        status.seen      = (px_reg != '0) && (py_reg != '0);
        status.trig      = trig_reg;
        status.have_ref  = have_ref_reg;
        status.div_done  = div_done;
        status.root_done = root_done;
        status.out_free  = out_free;
    end

    assign m_tvalid    = m_tvalid_reg;
    assign changed     = out_changed_reg;
    assign detected    = out_detected_reg;
    assign pos_x       = out_x_reg;
    assign pos_y       = out_y_reg;
    assign speed_valid = out_spd_valid_reg;
    assign speed       = out_speed_reg;

    // Checks
    `TPHS_ASSERT(a_emit_free, aclk, aresetn, (cmd == tphs_pkg::CMD_EMIT) |-> out_free, "result written over a pending one")
    `TPHS_ASSERT(a_speed_ref, aclk, aresetn, !have_speed_reg || have_ref_reg, "speed held without a reference")
    `TPHS_ASSERT(a_ref_pos, aclk, aresetn, !have_ref_reg || (have_pos_reg && have_since_reg), "reference held without position or time")
    `TPHS_ASSERT(a_lost_clear, aclk, aresetn, (cmd == tphs_pkg::CMD_LOST) |=> (!have_pos_reg && !have_speed_reg), "lost object left state behind")

endmodule

`default_nettype wire

// ===== rtl/tracked_position_hysteresis_speed.sv =====
// Tracked position with hysteresis and speed: one request is processed at a time.
// A lost object goes straight to the result; else both coordinates go through the divider,
// the position is updated, and a first reference or a speed sample (root, then divider) may follow.
// A new request is taken only after the last result is written to the output register; a
// result waiting there stalls only the next result. Divider: 16/24 steps; root: 17 steps.
// Reset (aresetn, synchronous, active low) clears all tracking state and restores registers.
`timescale 1ns / 1ps
`default_nettype none

module tracked_position_hysteresis_speed #(
    parameter int PIXEL_BITS = 12,
    parameter int TIME_BITS  = 32
) (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    // request channel
    input  wire                                     s_tvalid,
    output logic                                    s_tready,
    // pixel_x, pixel_y, time_us, zero pad to bytes
    input  wire [((2*PIXEL_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
    // result channel
    output logic                                    m_tvalid,
    input  wire                                     m_tready,
    // changed, pos_x, pos_y, speed, zero pad to bytes
    output logic [tphs_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // detected, speed_valid
    output logic [tphs_pkg::OUT_TUSER_W-1:0]        m_tuser,
    // configuration write channel
    input  wire                                     cfg_valid,
    output logic                                    cfg_ready,
    input  wire [tphs_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire [TIME_BITS-1:0]                     cfg_data
);

    localparam int IN_W = 2 * PIXEL_BITS + TIME_BITS;

    tphs_pkg::tphs_cmd_t    cmd;
    tphs_pkg::tphs_status_t status;

    logic                           changed;
    logic                           detected;
    logic [tphs_pkg::Q16_W-1:0]     pos_x;
    logic [tphs_pkg::Q16_W-1:0]     pos_y;
    logic                           speed_valid;
    logic [tphs_pkg::SPEED_W-1:0]   speed;

    tphs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tphs_dp #(
        .PIXEL_BITS (PIXEL_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .pixel_x     (s_tdata[PIXEL_BITS-1:0]),
        .pixel_y     (s_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
        .time_us     (s_tdata[IN_W-1:2*PIXEL_BITS]),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .changed     (changed),
        .detected    (detected),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .speed_valid (speed_valid),
        .speed       (speed)
    );

    // Register writes must only arrive while idle; the block does not enforce this. The port never stalls
    assign cfg_ready = 1'b1;

    assign m_tdata = {{tphs_pkg::OUT_PAD_W{1'b0}}, speed, pos_y, pos_x, changed};
    assign m_tuser = {speed_valid, detected};

endmodule

`default_nettype wire
